// ===== hdl/ahpf_pkg.sv =====
package ahpf_pkg;

   localparam int ADDR_BITS_DEFAULT = 25;

   localparam int OFFSET_W   = 25;
   localparam int LEN_W      = 26;
   localparam int EXP_W      = 5;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 26;
   localparam int CALC_W     = 34;

   localparam logic [CSR_IDX_W-1:0] REG_RUNTIME_SIZE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ALIGN_LOG2    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BANK_MODE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BANK_LOG2     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_SIZE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SPACE_SIZE    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HOLES_TRUSTED = 3'd6;

   localparam logic [STATUS_W-1:0] ST_HOLE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_TAIL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd3;

   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
   localparam logic [OP_W-1:0] OP_RANGE      = 4'd2;
   localparam logic [OP_W-1:0] OP_PIECE_FULL = 4'd3;
   localparam logic [OP_W-1:0] OP_BANK_TOP   = 4'd4;
   localparam logic [OP_W-1:0] OP_PIECE_TOP  = 4'd5;
   localparam logic [OP_W-1:0] OP_PIECE_PREV = 4'd6;
   localparam logic [OP_W-1:0] OP_ALIGN      = 4'd7;
   localparam logic [OP_W-1:0] OP_CHECK      = 4'd8;
   localparam logic [OP_W-1:0] OP_MCALC      = 4'd9;
   localparam logic [OP_W-1:0] OP_MCHECK     = 4'd10;
   localparam logic [OP_W-1:0] OP_TAIL       = 4'd11;
   localparam logic [OP_W-1:0] OP_TAIL_BANK  = 4'd12;
   localparam logic [OP_W-1:0] OP_REPORT     = 4'd13;

   typedef struct packed {
      logic [LEN_W-1:0] runtime_size;
      logic [EXP_W-1:0] align_log2;
      logic             bank_mode;
      logic [EXP_W-1:0] bank_log2;
      logic [LEN_W-1:0] image_size;
      logic [LEN_W-1:0] space_size;
      logic             holes_trusted;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic item_ok;
      logic bank_mode;
      logic big_runtime;
      logic align_ge_bank;
      logic fit;
      logic prev_ok;
      logic last_item;
      logic out_free;
   } stat_type;

   function automatic logic [CALC_W-1:0] align_up(input logic [CALC_W-1:0] v,
                                                  input logic [EXP_W-1:0] lg);
      logic [CALC_W-1:0] m;
      m = (CALC_W'(1) << lg) - CALC_W'(1);
      return (v + m) & ~m;
   endfunction

endpackage

// ===== hdl/ahpf_if.sv =====
interface ahpf_req_if import ahpf_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                holds_range;
   logic [OFFSET_W-1:0] range_start;
   logic [LEN_W-1:0]    range_length;
   logic                last_range;

   modport source (output valid, holds_range, range_start, range_length, last_range,
                   input ready);
   modport sink (input valid, holds_range, range_start, range_length, last_range,
                 output ready);
endinterface

interface ahpf_rsp_if import ahpf_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [OFFSET_W-1:0] placed_offset;
   logic [LEN_W-1:0]    placed_bytes;

   modport source (output valid, status, placed_offset, placed_bytes, input ready);
   modport sink (input valid, status, placed_offset, placed_bytes, output ready);
endinterface

interface ahpf_csr_if import ahpf_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/aligned_hole_placement_finder.sv =====
// Finds a start offset for a runtime image in a list of free ranges.
// Channels: req_chan carries one free range per transaction, the final one
// flagged by last_range; rsp_chan returns one result per list (status,
// placed_offset, placed_bytes); csr_chan writes the seven setup registers
// by index and is always ready.
// Sequencing: after its accept, a range passes through clamp and dispatch,
// then up to two piece/align/check passes (in bank mode with align_log2 >=
// bank_log2, a calc/check pair instead; or none), then done. The next range
// is not accepted before then. The final transaction adds tail, bank adjust
// and report before the result is registered on rsp_chan.
// One range is in flight at a time; req_chan.ready is high only when idle.
// Reset clears the setup registers to their defaults, the best-fit tracker
// and the output valid flag. If the receiver stalls, the result holds on
// rsp_chan; ranges are still taken meanwhile, and the next result waits in
// the sequencer until the output register frees up.
module aligned_hole_placement_finder import ahpf_pkg::*;
#(
   parameter int ADDR_BITS = ADDR_BITS_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   ahpf_req_if.sink    req_chan,
   ahpf_rsp_if.source  rsp_chan,
   ahpf_csr_if.sink    csr_chan
);

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type st;

   ahpf_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   ahpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .st        (st),
      .cmd       (cmd)
   );

   ahpf_dp #(
      .ADDR_BITS (ADDR_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .cmd          (cmd),
      .st           (st),
      .holds_range  (req_chan.holds_range),
      .range_start  (req_chan.range_start),
      .range_length (req_chan.range_length),
      .last_range   (req_chan.last_range),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .rsp_status   (rsp_chan.status),
      .rsp_offset   (rsp_chan.placed_offset),
      .rsp_bytes    (rsp_chan.placed_bytes)
   );

endmodule

// ===== hdl/ahpf_csr.sv =====
module ahpf_csr import ahpf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ahpf_csr_if.sink   csr_chan,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_RUNTIME_SIZE:  cfg_in.runtime_size  = csr_chan.data[LEN_W-1:0];
            REG_ALIGN_LOG2:    cfg_in.align_log2    = csr_chan.data[EXP_W-1:0];
            REG_BANK_MODE:     cfg_in.bank_mode     = csr_chan.data[0];
            REG_BANK_LOG2:     cfg_in.bank_log2     = csr_chan.data[EXP_W-1:0];
            REG_IMAGE_SIZE:    cfg_in.image_size    = csr_chan.data[LEN_W-1:0];
            REG_SPACE_SIZE:    cfg_in.space_size    = csr_chan.data[LEN_W-1:0];
            REG_HOLES_TRUSTED: cfg_in.holes_trusted = csr_chan.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.runtime_size  <= '0;
         cfg_ff.align_log2    <= EXP_W'(2);
         cfg_ff.bank_mode     <= 1'b0;
         cfg_ff.bank_log2     <= EXP_W'(16);
         cfg_ff.image_size    <= '0;
         cfg_ff.space_size    <= LEN_W'(33554432);
         cfg_ff.holes_trusted <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/ahpf_ctrl.sv =====
module ahpf_ctrl import ahpf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type st,
   output cmd_type  cmd
);

   localparam int SW = 4;
   localparam logic [SW-1:0] S_IDLE      = 4'd0;
   localparam logic [SW-1:0] S_RANGE     = 4'd1;
   localparam logic [SW-1:0] S_DISPATCH  = 4'd2;
   localparam logic [SW-1:0] S_PIECE_TOP = 4'd3;
   localparam logic [SW-1:0] S_PIECE_PRV = 4'd4;
   localparam logic [SW-1:0] S_ALIGN     = 4'd5;
   localparam logic [SW-1:0] S_CHECK     = 4'd6;
   localparam logic [SW-1:0] S_MCALC     = 4'd7;
   localparam logic [SW-1:0] S_MCHECK    = 4'd8;
   localparam logic [SW-1:0] S_DONE      = 4'd9;
   localparam logic [SW-1:0] S_TAIL      = 4'd10;
   localparam logic [SW-1:0] S_TAIL_BANK = 4'd11;
   localparam logic [SW-1:0] S_REPORT    = 4'd12;

   logic [SW-1:0] state_ff, state_in;
   logic          second_ff, second_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      second_in = second_ff;
      cmd.op    = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            cmd.op   = OP_RANGE;
            state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (!st.item_ok) begin
               state_in = S_DONE;
            end else if (!st.bank_mode) begin
               cmd.op    = OP_PIECE_FULL;
               second_in = 1'b1;
               state_in  = S_ALIGN;
            end else if (st.big_runtime) begin
               state_in = S_DONE;
            end else if (st.align_ge_bank) begin
               state_in = S_MCALC;
            end else begin
               cmd.op   = OP_BANK_TOP;
               state_in = S_PIECE_TOP;
            end
         end
         S_PIECE_TOP: begin
            cmd.op    = OP_PIECE_TOP;
            second_in = 1'b0;
            state_in  = S_ALIGN;
         end
         S_PIECE_PRV: begin
            cmd.op    = OP_PIECE_PREV;
            second_in = 1'b1;
            state_in  = S_ALIGN;
         end
         S_ALIGN: begin
            cmd.op   = OP_ALIGN;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.op = OP_CHECK;
            if (st.fit || second_ff || !st.prev_ok) begin
               state_in = S_DONE;
            end else begin
               state_in = S_PIECE_PRV;
            end
         end
         S_MCALC: begin
            cmd.op   = OP_MCALC;
            state_in = S_MCHECK;
         end
         S_MCHECK: begin
            cmd.op   = OP_MCHECK;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = st.last_item ? S_TAIL : S_IDLE;
         end
         S_TAIL: begin
            cmd.op   = OP_TAIL;
            state_in = S_TAIL_BANK;
         end
         S_TAIL_BANK: begin
            cmd.op   = OP_TAIL_BANK;
            state_in = S_REPORT;
         end
         S_REPORT: begin
            if (st.out_free) begin
               cmd.op   = OP_REPORT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
      end
   end

endmodule

// ===== hdl/ahpf_dp.sv =====
module ahpf_dp import ahpf_pkg::*;
#(
   parameter int ADDR_BITS = ADDR_BITS_DEFAULT
)
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  cmd_type             cmd,
   output stat_type            st,
   input  logic                holds_range,
   input  logic [OFFSET_W-1:0] range_start,
   input  logic [LEN_W-1:0]    range_length,
   input  logic                last_range,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [OFFSET_W-1:0] rsp_offset,
   output logic [LEN_W-1:0]    rsp_bytes
);

   localparam logic [CALC_W-1:0]   LIMIT     = CALC_W'(1) << ADDR_BITS;
   localparam logic [OFFSET_W-1:0] KEEP_MASK = OFFSET_W'(LIMIT - CALC_W'(1));

   logic                holds_ff, last_item_ff;
   logic [CALC_W-1:0]   rs_ff, len_ff, re_ff, top_ff, ps_ff, pe_ff, c_ff, tail_ff;
   logic [CALC_W-1:0]   rs_in, len_in, re_in, top_in, ps_in, pe_in, c_in, tail_in;
   logic                holds_in, last_item_in;
   logic                m_ok_ff, m_ok_in;
   logic                have_fit_ff, have_fit_in;
   logic [OFFSET_W-1:0] best_ff, best_in;
   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [OFFSET_W-1:0] out_offset_ff, out_offset_in;
   logic [LEN_W-1:0]    out_bytes_ff, out_bytes_in;

   logic [CALC_W-1:0] r, bsz, bmask, amask, sum, top_end, prev, space;
   logic              fit, better;

   assign r       = CALC_W'(cfg.runtime_size);
   assign bsz     = CALC_W'(1) << cfg.bank_log2;
   assign bmask   = bsz - CALC_W'(1);
   assign amask   = (CALC_W'(1) << cfg.align_log2) - CALC_W'(1);
   assign sum     = rs_ff + len_ff;
   assign top_end = top_ff + bsz;
   assign prev    = top_ff - bsz;
   assign space   = (CALC_W'(cfg.space_size) < LIMIT) ? CALC_W'(cfg.space_size) : LIMIT;
   assign fit     = (c_ff + r) <= pe_ff;
   assign better  = !have_fit_ff || (c_ff > CALC_W'(best_ff));

   assign st.item_ok       = holds_ff && cfg.holes_trusted && (r != '0) && (re_ff > rs_ff);
   assign st.bank_mode     = cfg.bank_mode;
   assign st.big_runtime   = r > bsz;
   assign st.align_ge_bank = cfg.align_log2 >= cfg.bank_log2;
   assign st.fit           = fit;
   assign st.prev_ok       = top_ff > rs_ff;
   assign st.last_item     = last_item_ff;
   assign st.out_free      = !out_valid_ff || rsp_ready;

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_offset = out_offset_ff;
   assign rsp_bytes  = out_bytes_ff;

   always_comb begin
      holds_in      = holds_ff;
      last_item_in  = last_item_ff;
      rs_in         = rs_ff;
      len_in        = len_ff;
      re_in         = re_ff;
      top_in        = top_ff;
      ps_in         = ps_ff;
      pe_in         = pe_ff;
      c_in          = c_ff;
      tail_in       = tail_ff;
      m_ok_in       = m_ok_ff;
      have_fit_in   = have_fit_ff;
      best_in       = best_ff;
      out_status_in = out_status_ff;
      out_offset_in = out_offset_ff;
      out_bytes_in  = out_bytes_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      case (cmd.op)
         OP_LOAD: begin
            holds_in     = holds_range;
            last_item_in = last_range;
            rs_in        = CALC_W'(range_start);
            len_in       = CALC_W'(range_length);
         end
         OP_RANGE: begin
            re_in = (sum > LIMIT) ? LIMIT : sum;
         end
         OP_PIECE_FULL: begin
            ps_in = rs_ff;
            pe_in = re_ff;
         end
         OP_BANK_TOP: begin
            top_in = (re_ff - CALC_W'(1)) & ~bmask;
         end
         OP_PIECE_TOP: begin
            ps_in = (top_ff > rs_ff) ? top_ff : rs_ff;
            pe_in = (top_end < re_ff) ? top_end : re_ff;
         end
         OP_PIECE_PREV: begin
            ps_in = (prev > rs_ff) ? prev : rs_ff;
            pe_in = top_ff;
         end
         OP_ALIGN: begin
            c_in = align_up(ps_ff, cfg.align_log2);
         end
         OP_CHECK: begin
            if (fit && better) begin
               have_fit_in = 1'b1;
               best_in     = c_ff[OFFSET_W-1:0] & KEEP_MASK;
            end
         end
         OP_MCALC: begin
            m_ok_in = re_ff >= r;
            c_in    = (re_ff - r) & ~amask;
         end
         OP_MCHECK: begin
            if (m_ok_ff && (c_ff >= rs_ff) && better) begin
               have_fit_in = 1'b1;
               best_in     = c_ff[OFFSET_W-1:0] & KEEP_MASK;
            end
         end
         OP_TAIL: begin
            tail_in = align_up(CALC_W'(cfg.image_size), cfg.align_log2);
         end
         OP_TAIL_BANK: begin
            if (cfg.bank_mode &&
                ((tail_ff >> cfg.bank_log2) != ((tail_ff + r - CALC_W'(1)) >> cfg.bank_log2))) begin
               tail_in = align_up(tail_ff, cfg.bank_log2);
            end
         end
         OP_REPORT: begin
            out_valid_in = 1'b1;
            have_fit_in  = 1'b0;
            best_in      = '0;
            if (r == '0) begin
               out_status_in = ST_EMPTY;
               out_offset_in = '0;
               out_bytes_in  = '0;
            end else if (have_fit_ff) begin
               out_status_in = ST_HOLE;
               out_offset_in = best_ff;
               out_bytes_in  = cfg.runtime_size;
            end else if ((tail_ff > space) || (r > space - tail_ff)) begin
               out_status_in = ST_NO_ROOM;
               out_offset_in = '0;
               out_bytes_in  = '0;
            end else begin
               out_status_in = ST_TAIL;
               out_offset_in = tail_ff[OFFSET_W-1:0];
               out_bytes_in  = cfg.runtime_size;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_fit_ff  <= 1'b0;
         best_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         have_fit_ff  <= have_fit_in;
         best_ff      <= best_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      holds_ff      <= holds_in;
      last_item_ff  <= last_item_in;
      rs_ff         <= rs_in;
      len_ff        <= len_in;
      re_ff         <= re_in;
      top_ff        <= top_in;
      ps_ff         <= ps_in;
      pe_ff         <= pe_in;
      c_ff          <= c_in;
      tail_ff       <= tail_in;
      m_ok_ff       <= m_ok_in;
      out_status_ff <= out_status_in;
      out_offset_ff <= out_offset_in;
      out_bytes_ff  <= out_bytes_in;
   end

endmodule
